// ===== sv/kbd_pkg.sv =====
// Shared types, codes and constants for the keyboard scan decoder.
// No dependencies; imported by every module of the block except kbd_ram.
`default_nettype none

package kbd_pkg;

    localparam int KBD_NUM_SCANS   = 90;
    localparam int KBD_NUM_TABLES  = 5;
    localparam int KBD_QUEUE_DEPTH = 2;

    localparam logic [6:0] KEY_ALT    = 7'h38;
    localparam logic [6:0] KEY_CTRL   = 7'h1D;
    localparam logic [6:0] KEY_LSHIFT = 7'h2A;
    localparam logic [6:0] KEY_RSHIFT = 7'h36;
    localparam logic [6:0] KEY_CAPS   = 7'h3A;

    localparam logic [15:0] SHIFT_STATUS_BASE = 16'h0200;

    typedef enum logic [2:0] {
        OP_SCAN   = 3'd0,
        OP_READ   = 3'd1,
        OP_PEEK   = 3'd2,
        OP_SHIFT  = 3'd3,
        OP_TWRITE = 3'd4,
        OP_HELD   = 3'd5
    } t_kbd_op;

    typedef enum logic [2:0] {
        TBL_NORMAL = 3'd0,
        TBL_CAPS   = 3'd1,
        TBL_SHIFT  = 3'd2,
        TBL_CTRL   = 3'd3,
        TBL_ALT    = 3'd4
    } t_kbd_tbl;

    typedef enum logic [1:0] {
        CMD_MAKE = 2'd0,
        CMD_READ = 2'd1,
        CMD_PEEK = 2'd2,
        CMD_WORD = 2'd3
    } t_kbd_kind;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] scan_code;
        logic [2:0] table_select;
        logic [6:0] entry_index;
        logic [7:0] table_value;
    } t_kbd_in;

    typedef struct packed {
        logic [15:0] result_word;
        logic        key_ready;
    } t_kbd_out;

    typedef struct packed {
        t_kbd_kind   kind;
        logic [15:0] word;
    } t_kbd_cmd;

    // table byte -> key word: ASCII low byte, or extended code in high byte
    function automatic logic [15:0] kbd_xlate(input logic [7:0] b);
        logic [7:0] hi;
        hi = (b >= 8'h85) ? (b & 8'h7F) : b;
        if (b < 8'h80) begin
            return {8'h00, b};
        end
        return {hi, 8'h00} & 16'hFF00;
    endfunction

endpackage

`default_nettype wire

// ===== sv/kbd_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module kbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 450
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/kbd_front.sv =====
// Front end: accepts beats, tracks held keys, owns the translation tables
// and hands classified commands to the queue. Uses kbd_pkg and kbd_ram.
`default_nettype none

module kbd_front #(
    parameter int NUM_SCANS = kbd_pkg::KBD_NUM_SCANS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire kbd_pkg::t_kbd_in i_in,
    output logic                  o_push,
    output kbd_pkg::t_kbd_cmd     o_cmd,
    input  wire logic             i_q_full
);

    import kbd_pkg::*;

    localparam int IW        = $clog2(NUM_SCANS);
    localparam int TBL_DEPTH = KBD_NUM_TABLES * NUM_SCANS;
    localparam int AW        = $clog2(TBL_DEPTH);

    logic [NUM_SCANS-1:0] r_held;
    logic                 r_s_valid;
    t_kbd_kind            r_s_kind;
    logic [15:0]          r_s_word;

    logic                 accept;
    logic                 is_make;
    logic                 code_rng;
    logic [IW-1:0]        key_idx;
    logic                 ent_rng;
    logic [IW-1:0]        ent_idx;
    logic                 sel_ok;
    logic [NUM_SCANS-1:0] held_make;
    t_kbd_tbl             tbl;
    logic [2:0]           addr_tbl;
    logic [IW-1:0]        addr_idx;
    logic [AW-1:0]        ram_addr;
    logic                 ram_en;
    logic                 ram_we;
    logic [7:0]           ram_rdata;
    logic                 shift_held;
    logic                 load;
    t_kbd_kind            load_kind;
    logic [15:0]          load_word;

    assign o_in_ready = !r_s_valid || !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = r_s_valid && !i_q_full;

    assign is_make  = !i_in.scan_code[7];
    assign code_rng = {1'b0, i_in.scan_code[6:0]} < 8'(NUM_SCANS);
    assign key_idx  = code_rng ? i_in.scan_code[IW-1:0] : '0;
    assign ent_rng  = {1'b0, i_in.entry_index} < 8'(NUM_SCANS);
    assign ent_idx  = ent_rng ? i_in.entry_index[IW-1:0] : '0;
    assign sel_ok   = i_in.table_select < 3'(KBD_NUM_TABLES);

    assign held_make  = r_held | (NUM_SCANS'(1) << key_idx);
    assign shift_held = r_held[KEY_LSHIFT[IW-1:0]] || r_held[KEY_RSHIFT[IW-1:0]];

    always_comb begin
        priority if (held_make[KEY_ALT[IW-1:0]]) begin
            tbl = TBL_ALT;
        end else if (held_make[KEY_CTRL[IW-1:0]]) begin
            tbl = TBL_CTRL;
        end else if (held_make[KEY_LSHIFT[IW-1:0]] || held_make[KEY_RSHIFT[IW-1:0]]) begin
            tbl = TBL_SHIFT;
        end else if (held_make[KEY_CAPS[IW-1:0]]) begin
            tbl = TBL_CAPS;
        end else begin
            tbl = TBL_NORMAL;
        end
    end

    always_comb begin
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        addr_tbl  = tbl;
        addr_idx  = key_idx;
        load      = 1'b0;
        load_kind = CMD_WORD;
        load_word = '0;
        unique case (t_kbd_op'(i_in.op))
            OP_SCAN: begin
                ram_en    = accept && is_make;
                load      = is_make;
                load_kind = CMD_MAKE;
            end
            OP_READ: begin
                load      = 1'b1;
                load_kind = CMD_READ;
            end
            OP_PEEK: begin
                load      = 1'b1;
                load_kind = CMD_PEEK;
            end
            OP_SHIFT: begin
                load      = 1'b1;
                load_word = SHIFT_STATUS_BASE | {15'd0, shift_held};
            end
            OP_TWRITE: begin
                ram_en   = accept && sel_ok && ent_rng;
                ram_we   = 1'b1;
                addr_tbl = i_in.table_select;
                addr_idx = ent_idx;
            end
            OP_HELD: begin
                load      = 1'b1;
                load_word = {15'd0, ent_rng && r_held[ent_idx]};
            end
            default: begin
            end
        endcase
    end

    assign ram_addr = AW'(AW'(addr_tbl) * AW'(NUM_SCANS)) + AW'(addr_idx);

    kbd_ram #(
        .WIDTH(8),
        .DEPTH(TBL_DEPTH)
    ) u_tables (
        .i_clk  (i_clk),
        .i_en   (ram_en),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(i_in.table_value),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= '0;
            r_s_valid <= 1'b0;
        end else begin
            if (accept && t_kbd_op'(i_in.op) == OP_SCAN) begin
                r_held[key_idx] <= is_make;
            end
            if (o_in_ready) begin
                r_s_valid <= accept && load;
                r_s_kind  <= load_kind;
                r_s_word  <= load_word;
            end
        end
    end

    assign o_cmd.kind = r_s_kind;
    assign o_cmd.word = (r_s_kind == CMD_MAKE) ? {8'h00, ram_rdata} : r_s_word;

`ifndef NO_ASSERTIONS
    a_make_sets_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && t_kbd_op'(i_in.op) == OP_SCAN && is_make |=> r_held[$past(key_idx)])
        else $error("make code did not mark key held");

    a_stall_holds_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_valid && i_q_full |=> r_s_valid && $stable(o_cmd))
        else $error("stalled front command changed");
`endif

endmodule

`default_nettype wire

// ===== sv/kbd_fifo.sv =====
// Short command queue between front and back ends.
// Uses kbd_pkg for the command type.
`default_nettype none

module kbd_fifo #(
    parameter int DEPTH = kbd_pkg::KBD_QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire kbd_pkg::t_kbd_cmd i_data,
    output logic                   o_full,
    output logic                   o_valid,
    output kbd_pkg::t_kbd_cmd      o_data,
    input  wire logic              i_pop
);

    import kbd_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_kbd_cmd      r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          do_pop;

    assign o_full  = r_count == CW'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + CW'(i_push) - CW'(do_pop);
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

// ===== sv/kbd_back.sv =====
// Back end: holds the pending key, executes queued commands and drives
// the registered result beat. Uses kbd_pkg.
`default_nettype none

module kbd_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire kbd_pkg::t_kbd_cmd i_cmd,
    output logic                   o_pop,
    output logic                   o_out_valid,
    output kbd_pkg::t_kbd_out      o_out,
    input  wire logic              i_out_ready
);

    import kbd_pkg::*;

    logic        r_out_valid;
    t_kbd_out    r_out;
    logic [15:0] r_pending;

    assign o_pop = i_valid && (i_cmd.kind == CMD_MAKE || !r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pending   <= '0;
        end else begin
            if (o_pop && i_cmd.kind != CMD_MAKE) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                unique case (i_cmd.kind)
                    CMD_MAKE: begin
                        r_pending <= kbd_xlate(i_cmd.word[7:0]);
                    end
                    CMD_READ: begin
                        r_out.result_word <= r_pending;
                        r_out.key_ready   <= 1'b0;
                        r_pending         <= '0;
                    end
                    CMD_PEEK: begin
                        r_out.result_word <= r_pending;
                        r_out.key_ready   <= r_pending != '0;
                    end
                    CMD_WORD: begin
                        r_out.result_word <= i_cmd.word;
                        r_out.key_ready   <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef NO_ASSERTIONS
    a_read_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_cmd.kind == CMD_READ |=> r_pending == '0)
        else $error("read key left pending key set");
`endif

endmodule

`default_nettype wire

// ===== sv/keyboard_scan_decoder.sv =====
// Path: front stage register, command queue, then registered result beat.
// Throughput: one input beat per cycle while o_in_ready is high; the front stage,
// the command queue and the output register decouple input from output stalls.
// Reset: synchronous active-low i_rst_n clears held keys, pending key, queue
// and valids; translation tables are not cleared and must be written before use.
`default_nettype none

module keyboard_scan_decoder #(
    parameter int NUM_SCANS   = kbd_pkg::KBD_NUM_SCANS,
    parameter int QUEUE_DEPTH = kbd_pkg::KBD_QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire kbd_pkg::t_kbd_in  i_in,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output kbd_pkg::t_kbd_out      o_out
);

    import kbd_pkg::*;

    logic     push;
    logic     q_full;
    logic     q_valid;
    logic     pop;
    t_kbd_cmd f_cmd;
    t_kbd_cmd q_cmd;

    kbd_front #(
        .NUM_SCANS(NUM_SCANS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in      (i_in),
        .o_push    (push),
        .o_cmd     (f_cmd),
        .i_q_full  (q_full)
    );

    kbd_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (f_cmd),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_data (q_cmd),
        .i_pop  (pop)
    );

    kbd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_cmd      (q_cmd),
        .o_pop      (pop),
        .o_out_valid(o_out_valid),
        .o_out      (o_out),
        .i_out_ready(i_out_ready)
    );

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for keyboard_scan_decoder: scan events and host requests
// checked against a cycle-free predictor, with random stalls on both sides.
// Depends on kbd_pkg (sv/kbd_pkg.sv) and the keyboard_scan_decoder RTL.

module testbench;
    import kbd_pkg::*;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          ITEM_TARGET  = 750;
    localparam int          TAIL_BEATS   = 100;
    localparam int          HOLD_AT      = 300;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 20;
    localparam logic [2:0]  OP_UNDEF_LO  = 3'd6;
    localparam logic [2:0]  OP_UNDEF_HI  = 3'd7;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    t_kbd_in  in_beat = '0;
    logic     out_ready = 1'b0;
    logic     o_in_ready;
    logic     o_out_valid;
    t_kbd_out o_out;

    keyboard_scan_decoder uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // predictor state
    bit          held_keys [KBD_NUM_SCANS];
    logic [6:0]  last_scan;
    logic [15:0] pending_key;
    logic [7:0]  xlat_tables [KBD_NUM_TABLES][KBD_NUM_SCANS];
    t_kbd_out    expected_replies [$];

    // stimulus-side shadow, keeps make codes on written table entries
    bit          gen_held [KBD_NUM_SCANS];
    bit          gen_written [KBD_NUM_TABLES][KBD_NUM_SCANS];
    t_kbd_in     beat_q [$];

    int          in_count = 0;
    int          total_beats = 0;
    int          errors = 0;
    int          cycle_count = 0;
    logic        in_fire_q = 1'b0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    function automatic logic [6:0] scan_index(input logic [6:0] code);
        return (code >= KBD_NUM_SCANS) ? 7'd0 : code;
    endfunction

    function automatic t_kbd_tbl select_table(input bit alt, input bit ctrl,
                                              input bit shft, input bit caps);
        if (alt) return TBL_ALT;
        if (ctrl) return TBL_CTRL;
        if (shft) return TBL_SHIFT;
        if (caps) return TBL_CAPS;
        return TBL_NORMAL;
    endfunction

    function automatic logic [15:0] key_word(input logic [7:0] v);
        if (v < 8'h80) return {8'h00, v};
        if (v >= 8'h85) return {1'b0, v[6:0], 8'h00};
        return {v, 8'h00};
    endfunction

    task automatic decode_request(input t_kbd_in b);
        t_kbd_out   r;
        logic [6:0] k;
        t_kbd_tbl   t;
        r = '0;
        case (b.op)
            OP_SCAN: begin
                k = scan_index(b.scan_code[6:0]);
                if (b.scan_code[7]) begin
                    held_keys[k] = 1'b0;
                end else begin
                    last_scan = k;
                    held_keys[k] = 1'b1;
                    t = select_table(held_keys[KEY_ALT], held_keys[KEY_CTRL],
                                     held_keys[KEY_LSHIFT] || held_keys[KEY_RSHIFT],
                                     held_keys[KEY_CAPS]);
                    pending_key = key_word(xlat_tables[int'(t)][k]);
                end
            end
            OP_READ: begin
                r.result_word = pending_key;
                pending_key = '0;
                expected_replies.push_back(r);
            end
            OP_PEEK: begin
                r.result_word = pending_key;
                r.key_ready = (pending_key != 16'h0000);
                expected_replies.push_back(r);
            end
            OP_SHIFT: begin
                r.result_word = SHIFT_STATUS_BASE |
                    {15'h0, held_keys[KEY_LSHIFT] || held_keys[KEY_RSHIFT]};
                expected_replies.push_back(r);
            end
            OP_TWRITE: begin
                if (b.table_select < KBD_NUM_TABLES && b.entry_index < KBD_NUM_SCANS)
                    xlat_tables[b.table_select][b.entry_index] = b.table_value;
            end
            OP_HELD: begin
                if (b.entry_index < KBD_NUM_SCANS)
                    r.result_word = {15'h0, held_keys[b.entry_index]};
                expected_replies.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic add_beat(input t_kbd_in b);
        if (b.op == OP_SCAN)
            gen_held[scan_index(b.scan_code[6:0])] = !b.scan_code[7];
        if (b.op == OP_TWRITE && b.table_select < KBD_NUM_TABLES &&
            b.entry_index < KBD_NUM_SCANS)
            gen_written[b.table_select][b.entry_index] = 1'b1;
        beat_q.push_back(b);
    endtask

    task automatic add_write(input logic [2:0] sel, input logic [6:0] idx,
                             input logic [7:0] val);
        t_kbd_in b;
        b = t_kbd_in'($urandom);
        b.op = OP_TWRITE;
        b.table_select = sel;
        b.entry_index = idx;
        b.table_value = val;
        add_beat(b);
    endtask

    task automatic add_req(input logic [2:0] op, input logic [6:0] idx);
        t_kbd_in b;
        b = t_kbd_in'($urandom);
        b.op = op;
        b.entry_index = idx;
        add_beat(b);
    endtask

    task automatic add_break(input logic [6:0] code);
        t_kbd_in b;
        b = t_kbd_in'($urandom);
        b.op = OP_SCAN;
        b.scan_code = {1'b1, code};
        add_beat(b);
    endtask

    // a make code, preceded by a table write if its entry is still unwritten
    task automatic add_make(input logic [6:0] code);
        t_kbd_in    b;
        logic [6:0] k;
        t_kbd_tbl   t;
        logic [7:0] v;
        k = scan_index(code);
        t = select_table(gen_held[KEY_ALT] || k == KEY_ALT,
                         gen_held[KEY_CTRL] || k == KEY_CTRL,
                         gen_held[KEY_LSHIFT] || gen_held[KEY_RSHIFT] ||
                         k == KEY_LSHIFT || k == KEY_RSHIFT,
                         gen_held[KEY_CAPS] || k == KEY_CAPS);
        if (!gen_written[int'(t)][k]) begin
            case ($urandom_range(0, 7))
                0: v = 8'h00;
                1, 2: v = 8'(8'h7E + $urandom_range(0, 8));
                default: v = 8'($urandom_range(0, 255));
            endcase
            add_write(t, k, v);
        end
        b = t_kbd_in'($urandom);
        b.op = OP_SCAN;
        b.scan_code = {1'b0, code};
        add_beat(b);
    endtask

    function automatic logic [6:0] modifier_key(input int n);
        case (n)
            0: return KEY_ALT;
            1: return KEY_CTRL;
            2: return KEY_LSHIFT;
            3: return KEY_RSHIFT;
            default: return KEY_CAPS;
        endcase
    endfunction

    initial begin : stimulus
        int         pick;
        logic [7:0] code;
        t_kbd_in    b;

        // directed: reset state, table classes, modifier priority, clamping
        add_req(OP_PEEK, 7'd0);
        add_req(OP_SHIFT, 7'd0);
        add_req(OP_HELD, 7'd127);
        add_write(TBL_NORMAL, 7'h1E, 8'h61);
        add_write(TBL_CAPS, 7'h1E, 8'h41);
        add_write(TBL_SHIFT, 7'h1E, 8'h85);
        add_write(TBL_CTRL, 7'h1E, 8'h00);
        add_write(TBL_ALT, 7'h1E, 8'hFF);
        add_write(TBL_NORMAL, 7'd89, 8'h80);
        add_write(3'd7, 7'h1E, 8'h33);
        add_write(TBL_NORMAL, 7'd127, 8'h33);
        add_make(7'h1E);
        add_req(OP_READ, 7'd0);
        add_req(OP_READ, 7'd0);
        add_make(KEY_CAPS);
        add_make(7'h1E);
        add_make(KEY_RSHIFT);
        add_make(7'h1E);
        add_req(OP_SHIFT, 7'd0);
        add_make(KEY_CTRL);
        add_make(7'h1E);
        add_req(OP_PEEK, 7'd0);
        add_make(KEY_ALT);
        add_make(7'h1E);
        add_req(OP_PEEK, 7'd0);
        add_break(KEY_ALT);
        add_break(KEY_CTRL);
        add_break(KEY_RSHIFT);
        add_break(KEY_CAPS);
        add_make(7'd89);
        add_req(OP_PEEK, 7'd89);
        add_make(7'h5A);
        add_req(OP_HELD, 7'd0);
        add_break(7'h7F);
        add_req(OP_HELD, 7'd0);
        add_req(OP_UNDEF_HI, 7'd0);

        while (beat_q.size() < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            b = t_kbd_in'($urandom);
            if (pick < 40) begin
                if ($urandom_range(0, 19) == 0)
                    add_make(7'($urandom_range(90, 127)));
                else
                    add_make(7'($urandom_range(0, 89)));
            end else if (pick < 48) begin
                add_make(modifier_key($urandom_range(0, 4)));
            end else if (pick < 60) begin
                add_break(modifier_key($urandom_range(0, 4)));
            end else if (pick < 66) begin
                add_break(7'($urandom_range(0, 127)));
            end else if (pick < 76) begin
                add_req(OP_READ, b.entry_index);
            end else if (pick < 83) begin
                add_req(OP_PEEK, b.entry_index);
            end else if (pick < 88) begin
                add_req(OP_SHIFT, b.entry_index);
            end else if (pick < 93) begin
                if ($urandom_range(0, 2) == 0)
                    add_req(OP_HELD, modifier_key($urandom_range(0, 4)));
                else
                    add_req(OP_HELD, b.entry_index);
            end else if (pick < 97) begin
                b.op = OP_TWRITE;
                add_beat(b);
            end else if (pick < 99) begin
                code = 8'($urandom_range(0, 255));
                if (code[7])
                    add_break(code[6:0]);
                else
                    add_make(code[6:0]);
            end else begin
                b.op = $urandom_range(0, 1) ? OP_UNDEF_HI : OP_UNDEF_LO;
                add_beat(b);
            end
        end
        total_beats = beat_q.size();

        repeat (9) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
        while (in_count < total_beats) @(posedge clk);
        while (expected_replies.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    // driver: new beat at the falling edge once the previous one was taken
    always @(negedge clk) begin
        if (rst_n && (!in_valid || in_fire_q)) begin
            if (gap_left > 0) begin
                in_valid <= 1'b0;
                gap_left--;
            end else if (beat_q.size() > 0) begin
                in_beat <= beat_q.pop_front();
                in_valid <= 1'b1;
                if (beat_q.size() > TAIL_BEATS && (in_count % 192) >= 48 &&
                    $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 16);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off to back up the block
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (!hold_done && in_count >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (beat_q.size() > TAIL_BEATS && (in_count % 160) >= 40 &&
                     $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 16) - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // monitor: predict on accepted input beats, check accepted output beats
    always @(posedge clk) begin : monitor
        t_kbd_out want;
        in_fire_q <= rst_n && in_valid && o_in_ready;
        if (rst_n) begin
            if (o_out_valid && out_ready) begin
                if (expected_replies.size() == 0) begin
                    $display("%0t: unexpected reply, expected none, got %h/%b",
                             $realtime, o_out.result_word, o_out.key_ready);
                    errors++;
                end else begin
                    want = expected_replies.pop_front();
                    if (o_out.result_word !== want.result_word) begin
                        $display("%0t: result_word expected %h got %h",
                                 $realtime, want.result_word, o_out.result_word);
                        errors++;
                    end
                    if (o_out.key_ready !== want.key_ready) begin
                        $display("%0t: key_ready expected %b got %b",
                                 $realtime, want.key_ready, o_out.key_ready);
                        errors++;
                    end
                end
            end
            if (in_valid && o_in_ready) begin
                decode_request(in_beat);
                in_count++;
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

endmodule
